// ===== design/rbad_pkg.sv =====
// Package: shared constants and types for the RGB box-average decimator
package rbad_pkg;
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_GROUP = 64;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int GRP_W = $clog2(MAX_GROUP + 1);
  localparam int WID_W = COL_W + 1;
  localparam int HGT_W = 13;
  localparam int ROW_W = 12;
  localparam int LANE_W = 16;
  localparam int QUO_W = 16;

  localparam logic [1:0] REG_GROUP  = 2'd0;
  localparam logic [1:0] REG_VERT   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
  } pix_out_t;

  typedef struct packed {
    logic [LANE_W-1:0] r;
    logic [LANE_W-1:0] g;
    logic [LANE_W-1:0] b;
  } sums_t;

  typedef struct packed {
    logic [GRP_W-1:0] m;
    logic             vert;
    logic [WID_W-1:0] w;
    logic [HGT_W-1:0] h;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;
    logic div_last;
    logic busy;
  } sts_t;

  function automatic logic [LANE_W-1:0] sat_add(input logic [LANE_W-1:0] a,
                                                 input logic [7:0] b);
    logic [LANE_W:0] s;
    s = {1'b0, a} + {{(LANE_W-7){1'b0}}, b};
    return s[LANE_W] ? {LANE_W{1'b1}} : s[LANE_W-1:0];
  endfunction
endpackage

// ===== design/rbad_if.sv =====
// Interfaces: valid/ready pixel channels
interface rbad_in_if;
  import rbad_pkg::*;
  logic valid;
  logic ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic frame_start;
  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface rbad_out_if;
  logic valid;
  logic ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic row_end;
  modport source (output valid, red_out, green_out, blue_out, row_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, row_end, output ready);
endinterface

// ===== design/rbad_datapath.sv =====
// Datapath: counters, run sums, line store and serial divider
module rbad_datapath import rbad_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  pix_in_t  pix,
  input  cmd_t     cmd,
  output sts_t     sts,
  output pix_out_t res
);
  logic [COL_W:0]    column_count;
  logic [ROW_W:0]    row_count;
  logic [GRP_W-1:0]  group_count;
  sums_t             run_sums;
  sums_t             column_sums [MAX_WIDTH];
  sums_t             line_rd;
  logic              emit_q;

  // pending work captured at load
  pix_in_t           pend;
  logic [COL_W:0]    pc_col;
  logic [ROW_W:0]    pc_row;
  logic [GRP_W-1:0]  pc_grp;

  sums_t             dsum;
  logic              dlast;
  logic [QUO_W-1:0]  quo [3];
  logic [GRP_W:0]    rem [3];
  logic [4:0]        bitc;

  // second-phase logic, uses line_rd, registered from the pc_col captured at load
  logic [WID_W-1:0]  full_h;
  logic [HGT_W:0]    full_v;

  // group-aligned width and height: remainder by m, one bit per cycle after a config change
  cfg_t              cfg_seen;
  logic              frun;
  logic [3:0]        fcnt;
  logic [HGT_W-1:0]  fw_x;
  logic [GRP_W:0]    fw_rem, fh_rem, fw_tr, fh_tr, fw_nx, fh_nx;
  logic              cfg_dirty;

  assign cfg_dirty = (cfg != cfg_seen);
  assign fw_x = {{(HGT_W-WID_W){1'b0}}, cfg_seen.w};
  assign fw_tr = {fw_rem[GRP_W-1:0], fw_x[fcnt]};
  assign fh_tr = {fh_rem[GRP_W-1:0], cfg_seen.h[fcnt]};
  assign fw_nx = (fw_tr >= {1'b0, cfg_seen.m}) ? fw_tr - {1'b0, cfg_seen.m} : fw_tr;
  assign fh_nx = (fh_tr >= {1'b0, cfg_seen.m}) ? fh_tr - {1'b0, cfg_seen.m} : fh_tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_seen <= '0;
      frun <= 1'b0;
      fcnt <= '0;
      fw_rem <= '0;
      fh_rem <= '0;
      full_h <= '0;
      full_v <= '0;
    end else if (cfg_dirty) begin
      cfg_seen <= cfg;
      frun <= 1'b1;
      fcnt <= 4'(HGT_W-1);
      fw_rem <= '0;
      fh_rem <= '0;
    end else if (frun) begin
      fw_rem <= fw_nx;
      fh_rem <= fh_nx;
      if (fcnt == '0) begin
        frun <= 1'b0;
        full_h <= cfg_seen.w - {{(WID_W-GRP_W-1){1'b0}}, fw_nx};
        full_v <= {1'b0, cfg_seen.h} - {{(HGT_W-GRP_W){1'b0}}, fh_nx};
      end else begin
        fcnt <= fcnt - 1'b1;
      end
    end
  end

  assign sts.busy = cfg_dirty || frun;

  logic [1:0] phase;

  always_ff @(posedge clk) begin
    line_rd <= column_sums[pc_col[COL_W-1:0]];
  end

  sums_t prior, s;
  logic  in_rows, do_acc, gdone, lst, rowdone;
  always_comb begin
    prior = (pc_grp == '0) ? sums_t'('0) : line_rd;
    in_rows = {1'b0, pc_row} < (ROW_W+2)'(full_v);
    if (!cfg.vert) begin
      do_acc = {1'b0, pc_col} < (COL_W+2)'(full_h);
      s.r = sat_add(run_sums.r, pend.red);
      s.g = sat_add(run_sums.g, pend.green);
      s.b = sat_add(run_sums.b, pend.blue);
      lst = ({1'b0, pc_col} + 1'b1) >= (COL_W+2)'(full_h);
    end else begin
      do_acc = in_rows;
      s.r = sat_add(prior.r, pend.red);
      s.g = sat_add(prior.g, pend.green);
      s.b = sat_add(prior.b, pend.blue);
      lst = ({1'b0, pc_col} + 1'b1) >= (COL_W+2)'(cfg.w);
    end
    gdone = ({1'b0, pc_grp} + 1'b1) >= {1'b0, cfg.m};
    rowdone = ({1'b0, pc_col} + 1'b1) >= (COL_W+2)'(cfg.w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      group_count <= '0;
      run_sums <= '0;
      emit_q <= 1'b0;
      phase <= '0;
    end else begin
      emit_q <= 1'b0;
      if (cmd.load) begin
        pend <= pix;
        pc_col <= pix.frame_start ? '0 : column_count;
        pc_row <= pix.frame_start ? '0 : row_count;
        pc_grp <= pix.frame_start ? '0 : group_count;
        if (pix.frame_start) run_sums <= '0;
        phase <= 2'd1;
      end else if (phase == 2'd1) begin
        phase <= 2'd2;
      end else if (phase == 2'd2) begin
        phase <= 2'd0;
        column_count <= rowdone ? '0 : pc_col + 1'b1;
        if (rowdone) begin
          if ((pc_row + 1'b1) >= (ROW_W+1)'(cfg.h)) row_count <= '0;
          else row_count <= pc_row + 1'b1;
        end else begin
          row_count <= pc_row;
        end
        if (!cfg.vert) begin
          if (do_acc) begin
            if (gdone) begin
              dsum <= s; dlast <= lst; emit_q <= 1'b1;
              run_sums <= '0; group_count <= '0;
            end else begin
              run_sums <= s; group_count <= pc_grp + 1'b1;
            end
          end else begin
            group_count <= pc_grp;
          end
          if (rowdone) begin
            run_sums <= '0; group_count <= '0;
          end
        end else begin
          if (do_acc && pc_col < (COL_W+1)'(MAX_WIDTH)) begin
            if (gdone) begin
              dsum <= s; dlast <= lst; emit_q <= 1'b1;
            end else begin
              column_sums[pc_col[COL_W-1:0]] <= s;
            end
          end
          group_count <= pc_grp;
          if (rowdone && in_rows) group_count <= gdone ? '0 : pc_grp + 1'b1;
        end
        if (rowdone && (pc_row + 1'b1) >= (ROW_W+1)'(cfg.h)) group_count <= '0;
      end
    end
  end

  assign sts.emit = emit_q;
  assign sts.div_last = (bitc == 5'd0);

  // restoring divider, one quotient bit per lane per cycle
  logic [GRP_W:0] tr [3];
  logic [LANE_W-1:0] dl [3];
  logic [QUO_W-1:0] qn [3];
  assign dl[0] = dsum.r;
  assign dl[1] = dsum.g;
  assign dl[2] = dsum.b;
  always_comb
    for (int i = 0; i < 3; i++) begin
      tr[i] = {rem[i][GRP_W-1:0], dl[i][bitc[3:0]]};
      qn[i] = {quo[i][QUO_W-2:0], tr[i] >= {1'b0, cfg.m}};
    end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      bitc <= 5'd15;
      for (int i = 0; i < 3; i++) begin
        rem[i] <= '0;
        quo[i] <= '0;
      end
    end else if (cmd.div_step) begin
      bitc <= bitc - 1'b1;
      for (int i = 0; i < 3; i++) begin
        quo[i] <= qn[i];
        if (tr[i] >= {1'b0, cfg.m}) rem[i] <= tr[i] - {1'b0, cfg.m};
        else rem[i] <= tr[i];
      end
    end
  end

  function automatic logic [7:0] sat8(input logic [QUO_W-1:0] q);
    return (q > 16'd255) ? 8'hFF : q[7:0];
  endfunction

  // last step: load the quotient including the final bit
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.red <= sat8(qn[0]);
      res.green <= sat8(qn[1]);
      res.blue <= sat8(qn[2]);
      res.row_end <= dlast;
    end
  end
endmodule

// ===== design/rbad_ctrl.sv =====
// Controller: sequences load, update, divide and output
module rbad_ctrl import rbad_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [2:0] {IDLE, RD, UPD, CHK, DIV, HOLD} state_t;
  state_t state;

  assign in_ready = (state == IDLE) && !sts.busy;

  always_comb begin
    cmd = '0;
    cmd.load = in_ready && in_valid;
    cmd.div_start = (state == CHK) && sts.emit;
    cmd.div_step = (state == DIV);
    cmd.out_load = (state == DIV) && sts.div_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        IDLE: if (in_valid && !sts.busy) state <= RD;
        RD:   state <= UPD;
        UPD:  state <= CHK;
        CHK:  state <= sts.emit ? HOLD : IDLE;
        HOLD: if (!out_valid || out_ready) state <= DIV;
        DIV: begin
          if (sts.div_last) begin
            state <= IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ===== design/rgb_box_average_decimator_top.sv =====
// Top level: RGB box-average decimator with APB configuration
//   channel | dir | words
//   pix_in  | in  | red_in, green_in, blue_in, frame_start
//   pix_out | out | red_out, green_out, blue_out, row_end
//   apb     | in  | group_size, vertical_mode, frame_width, frame_height
// A word passes accept, read, update and check, and the 16-step serial divider
// when it produces an output (one quotient bit per cycle); a new word is accepted only in idle.
// The line store is read in the cycle after accept and written on the update cycle.
// After reset or a register write that changes the configuration, input is held
// while the group-aligned width and height are recomputed (13-step remainder).
// Reset is synchronous; the line store is not cleared.
// A stalled output holds the controller before the divider steps.
module rgb_box_average_decimator_top import rbad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rbad_in_if.sink     pix_in,
  rbad_out_if.source  pix_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [6:0]  group_size;
  logic        vertical_mode;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  pix_in_t pix;
  pix_out_t res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= 7'd2;
      vertical_mode <= 1'b0;
      frame_width <= 11'd640;
      frame_height <= 13'd480;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_GROUP:  group_size <= pwdata[6:0];
        REG_VERT:   vertical_mode <= pwdata[0];
        REG_WIDTH:  frame_width <= pwdata[10:0];
        REG_HEIGHT: frame_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GROUP:  prdata = {25'd0, group_size};
      REG_VERT:   prdata = {31'd0, vertical_mode};
      REG_WIDTH:  prdata = {21'd0, frame_width};
      REG_HEIGHT: prdata = {19'd0, frame_height};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.m = (group_size == 7'd0) ? GRP_W'(1) :
            (group_size > 7'(MAX_GROUP)) ? GRP_W'(MAX_GROUP) : GRP_W'(group_size);
    cfg.w = (frame_width == 11'd0) ? WID_W'(1) :
            (frame_width > 11'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : WID_W'(frame_width);
    cfg.h = (frame_height == 13'd0) ? HGT_W'(1) :
            (frame_height > 13'd4096) ? HGT_W'(4096) : frame_height;
    cfg.vert = vertical_mode;
  end

  assign pix.red = pix_in.red_in;
  assign pix.green = pix_in.green_in;
  assign pix.blue = pix_in.blue_in;
  assign pix.frame_start = pix_in.frame_start;

  rbad_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(pix_in.valid), .in_ready(pix_in.ready),
    .out_valid(pix_out.valid), .out_ready(pix_out.ready),
    .sts, .cmd
  );

  rbad_datapath u_dp (.clk, .rst, .cfg, .pix, .cmd, .sts, .res);

  assign pix_out.red_out = res.red;
  assign pix_out.green_out = res.green;
  assign pix_out.blue_out = res.blue;
  assign pix_out.row_end = res.row_end;
endmodule
